@@ rtl/cpvg_pkg.sv @@
// Shared types, constants and helpers for the circle polygon vertex generator.
package cpvg_pkg;

  localparam int unsigned EdgeCountReset = 32;
  localparam int unsigned AngleStepReset = 2048;
  localparam logic [63:0] HalfPiQ30      = 64'd1686629713;
  localparam logic [15:0] QuarterTurn    = 16'd16384;

  typedef enum logic [7:0] {
    CFG_EDGE_COUNT = 8'd0,
    CFG_ANGLE_STEP = 8'd1
  } cfg_index_e;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] rim_x;
    logic signed [31:0] rim_y;
    logic signed [31:0] rim_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } cpvg_in_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [5:0]         vertex_number;
    logic               last_vertex;
  } cpvg_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       st_prod;
    logic       st_dot;
    logic       st_scale;
    logic       st_proj;
    logic       v_addr;
    logic       v_rom;
    logic       v_mprod;
    logic       v_msum;
    logic       v_mul;
    logic       load_out;
    logic       first;
    logic       last;
    logic [5:0] vertex_number;
  } cpvg_cmd_t;

  // Clamp a signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/cpvg_ctrl.sv @@
// Controller state machine that sequences projection setup and vertex generation.
module cpvg_ctrl #(
  parameter int unsigned MAX_EDGES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [6:0]          edge_count_i,
  output cpvg_pkg::cpvg_cmd_t cmd_o
);
  import cpvg_pkg::*;

  localparam int unsigned CW = $clog2(MAX_EDGES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD, ST_DOT, ST_SCALE, ST_PROJ,
    ST_ADDR, ST_ROM, ST_MPROD, ST_MSUM, ST_MUL, ST_OUT
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   vcnt_q, vcnt_d;
  logic [CW-1:0]   last_idx_q, last_idx_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;
  int unsigned     ec;
  logic [31:0]     vnum_wide;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign vnum_wide   = 32'(vcnt_q);

  always_comb begin
    ec = 32'(edge_count_i);
    if (ec < 3) begin
      ec = 3;
    end
    if (ec > MAX_EDGES) begin
      ec = MAX_EDGES;
    end
  end

  always_comb begin
    state_d     = state_q;
    vcnt_d      = vcnt_q;
    last_idx_d  = last_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.first         = (vcnt_q == '0);
    cmd_o.last          = (vcnt_q == last_idx_q);
    cmd_o.vertex_number = vnum_wide[5:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          vcnt_d        = '0;
          last_idx_d    = CW'(ec - 1);
          state_d       = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.st_prod = 1'b1;
        state_d       = ST_DOT;
      end
      ST_DOT: begin
        cmd_o.st_dot = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.st_scale = 1'b1;
        state_d        = ST_PROJ;
      end
      ST_PROJ: begin
        cmd_o.st_proj = 1'b1;
        state_d       = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.v_addr = 1'b1;
        state_d      = ST_ROM;
      end
      ST_ROM: begin
        cmd_o.v_rom = 1'b1;
        state_d     = ST_MPROD;
      end
      ST_MPROD: begin
        cmd_o.v_mprod = 1'b1;
        state_d       = ST_MSUM;
      end
      ST_MSUM: begin
        cmd_o.v_msum = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.v_mul = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          if (vcnt_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            vcnt_d  = vcnt_q + 1'b1;
            state_d = ST_ADDR;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcnt_q      <= '0;
      last_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcnt_q      <= vcnt_d;
      last_idx_q  <= last_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A stalled vertex holds the controller and its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && out_stall_i)
      |=> (state_q == ST_OUT && $stable(vcnt_q)))
    else $error("vertex sequence advanced while output was blocked");

  // Each accepted request starts at vertex zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (vcnt_q == '0 && state_q == ST_PROD))
    else $error("request did not start at vertex zero");

  // The vertex count never passes the last index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (vcnt_q <= last_idx_q && last_idx_q >= CW'(2)))
    else $error("vertex count out of range");

endmodule

@@ rtl/cpvg_datapath.sv @@
// Datapath: projection, sine table lookup, rotation matrix and vertex output.
module cpvg_datapath #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpvg_pkg::cpvg_in_t  in_data_i,
  input  logic [15:0]         angle_step_i,
  input  cpvg_pkg::cpvg_cmd_t cmd_i,
  output cpvg_pkg::cpvg_out_t out_data_o
);
  import cpvg_pkg::*;

  localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);

  typedef logic [14:0] rom_t [SINE_TABLE_DEPTH + 1];

  function automatic logic [14:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x    = (HalfPiQ30 * 64'(k)) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    r = (sum + 64'sd32768) >>> 16;
    if (r > 64'sd16384) begin
      r = 64'sd16384;
    end
    if (r < 64'sd0) begin
      r = 64'sd0;
    end
    return r[14:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam rom_t SineRom = build_rom();

  // Quarter-wave index for a phase; the sign follows the upper quadrant bit.
  function automatic logic [IW-1:0] table_index(input logic [15:0] p);
    logic [IW+13:0] scaled;
    logic [IW-1:0]  j;
    logic [IW-1:0]  idx;
    scaled = (IW + 14)'(p[13:0]) * (IW + 14)'(SINE_TABLE_DEPTH);
    j      = scaled[IW+13:14];
    idx    = p[14] ? (IW'(SINE_TABLE_DEPTH) - j) : j;
    return idx;
  endfunction

  logic signed [31:0] c_q [3];
  logic signed [31:0] r_q [3];
  logic signed [15:0] n_q [3];
  logic signed [48:0] prod_q [3];
  logic signed [36:0] d_q;
  logic signed [52:0] e_q [3];
  logic signed [31:0] nn_q [3][3];
  logic signed [31:0] p_q [3];
  logic signed [32:0] t_q [3];
  logic [15:0]        ph_q;
  logic [15:0]        cos_ph;
  logic [IW-1:0]      sin_idx_q, cos_idx_q;
  logic               sin_neg_q, cos_neg_q;
  logic [14:0]        sin_raw_q, cos_raw_q;
  logic signed [15:0] s_val, co_val;
  logic signed [16:0] omc;
  logic signed [48:0] m1_q [3][3];
  logic signed [15:0] co_q;
  logic signed [31:0] sn_q [3];
  logic signed [49:0] m_full [3][3];
  logic signed [23:0] mq_q [3][3];
  logic signed [56:0] pr_q [3][3];
  logic signed [39:0] proj [3];
  logic signed [31:0] p_d [3];
  logic signed [58:0] acc [3];
  logic signed [43:0] vr [3];
  cpvg_out_t          out_q;

  assign out_data_o = out_q;
  assign cos_ph     = ph_q + QuarterTurn;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      proj[a] = 40'(r_q[a]) - 40'((e_q[a] + 53'sd8192) >>> 14);
      p_d[a]  = sat32(64'(proj[a]));
    end
  end

  always_comb begin
    s_val  = sin_neg_q ? -$signed(16'(sin_raw_q)) : $signed(16'(sin_raw_q));
    co_val = cos_neg_q ? -$signed(16'(cos_raw_q)) : $signed(16'(cos_raw_q));
    omc    = 17'sd16384 - 17'(co_val);
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        m_full[a][b] = 50'(m1_q[a][b]);
      end
      m_full[a][a] = m_full[a][a] + (50'(co_q) <<< 28);
    end
    m_full[0][1] = m_full[0][1] - (50'(sn_q[2]) <<< 14);
    m_full[1][0] = m_full[1][0] + (50'(sn_q[2]) <<< 14);
    m_full[0][2] = m_full[0][2] + (50'(sn_q[1]) <<< 14);
    m_full[2][0] = m_full[2][0] - (50'(sn_q[1]) <<< 14);
    m_full[1][2] = m_full[1][2] - (50'(sn_q[0]) <<< 14);
    m_full[2][1] = m_full[2][1] + (50'(sn_q[0]) <<< 14);
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc[a] = 59'(pr_q[a][0]) + 59'(pr_q[a][1]) + 59'(pr_q[a][2]);
      vr[a]  = 44'(c_q[a]) + 44'((acc[a] + 59'sd32768) >>> 16);
    end
  end

  // Phase accumulator: cleared per request, advanced once per vertex.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
    end else if (cmd_i.load_in) begin
      ph_q <= '0;
    end else if (cmd_i.load_out) begin
      ph_q <= ph_q + angle_step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      c_q[0] <= in_data_i.center_x;
      c_q[1] <= in_data_i.center_y;
      c_q[2] <= in_data_i.center_z;
      r_q[0] <= in_data_i.rim_x;
      r_q[1] <= in_data_i.rim_y;
      r_q[2] <= in_data_i.rim_z;
      n_q[0] <= in_data_i.axis_x;
      n_q[1] <= in_data_i.axis_y;
      n_q[2] <= in_data_i.axis_z;
    end
    if (cmd_i.st_prod) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= 49'(33'(r_q[a]) - 33'(c_q[a])) * 49'(n_q[a]);
      end
    end
    if (cmd_i.st_dot) begin
      d_q <= 37'((51'(prod_q[0]) + 51'(prod_q[1]) + 51'(prod_q[2]) + 51'sd8192) >>> 14);
    end
    if (cmd_i.st_scale) begin
      for (int a = 0; a < 3; a++) begin
        e_q[a] <= 53'(d_q) * 53'(n_q[a]);
        for (int b = 0; b < 3; b++) begin
          nn_q[a][b] <= 32'(n_q[a]) * 32'(n_q[b]);
        end
      end
    end
    if (cmd_i.st_proj) begin
      for (int a = 0; a < 3; a++) begin
        p_q[a] <= p_d[a];
        t_q[a] <= 33'(p_d[a]) - 33'(c_q[a]);
      end
    end
    if (cmd_i.v_addr) begin
      sin_idx_q <= table_index(ph_q);
      sin_neg_q <= ph_q[15];
      cos_idx_q <= table_index(cos_ph);
      cos_neg_q <= cos_ph[15];
    end
    if (cmd_i.v_rom) begin
      sin_raw_q <= SineRom[sin_idx_q];
      cos_raw_q <= SineRom[cos_idx_q];
    end
    if (cmd_i.v_mprod) begin
      co_q <= co_val;
      for (int a = 0; a < 3; a++) begin
        sn_q[a] <= 32'(n_q[a]) * 32'(s_val);
        for (int b = 0; b < 3; b++) begin
          m1_q[a][b] <= 49'(nn_q[a][b]) * 49'(omc);
        end
      end
    end
    if (cmd_i.v_msum) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          mq_q[a][b] <= 24'((m_full[a][b] + 50'sd33554432) >>> 26);
        end
      end
    end
    if (cmd_i.v_mul) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          pr_q[a][b] <= 57'(mq_q[a][b]) * 57'(t_q[b]);
        end
      end
    end
    if (cmd_i.load_out) begin
      out_q.vertex_x      <= cmd_i.first ? p_q[0] : sat32(64'(vr[0]));
      out_q.vertex_y      <= cmd_i.first ? p_q[1] : sat32(64'(vr[1]));
      out_q.vertex_z      <= cmd_i.first ? p_q[2] : sat32(64'(vr[2]));
      out_q.vertex_number <= cmd_i.vertex_number;
      out_q.last_vertex   <= cmd_i.last;
    end
  end

endmodule

@@ rtl/circle_polygon_vertex_generator_core.sv @@
// Top level of the circle polygon vertex generator: configuration and glue.
//
// Each input request carries a circle center, a rim point (both Q16.16) and a
// unit plane normal (Q1.14). The rim point is projected into the plane, and
// the block then emits edge_count vertices: the projected point first, then
// that point rotated about the normal through the center by multiples of
// angle_step (a 16-bit fraction of a turn). Sine and cosine come from a
// quarter-wave table held in a read-only memory.
// The input channel takes a request when in_valid_i is high and in_stall_o is
// low; in_stall_o stays high from the accepted request until its last vertex
// has been loaded into the output register. The accepted request passes through
// the setup steps (products, dot product, scaling, projection), and each vertex
// then passes through the steps of the shared rotation datapath (table address,
// table read, matrix products, matrix sum, matrix-vector product, output load).
// The output register holds a vertex while out_stall_i is high; the vertex
// sequence waits at its output load while stalled, and no vertex is lost or
// repeated. Configuration writes (index 0: edge_count, index 1: angle_step)
// are always accepted and must be issued only while the block is idle. Reset
// clears the control logic and restores edge_count to 32 and angle_step to
// 2048.
module circle_polygon_vertex_generator_core #(
  parameter int unsigned MAX_EDGES        = 64,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cpvg_pkg::cpvg_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpvg_pkg::cpvg_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import cpvg_pkg::*;

  logic [6:0]  edge_count_q;
  logic [15:0] angle_step_q;
  cpvg_cmd_t   cmd;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= 7'(EdgeCountReset);
      angle_step_q <= 16'(AngleStepReset);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EDGE_COUNT: edge_count_q <= cfg_data_i[6:0];
        CFG_ANGLE_STEP: angle_step_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cpvg_ctrl #(
    .MAX_EDGES(MAX_EDGES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .edge_count_i (edge_count_q),
    .cmd_o        (cmd)
  );

  cpvg_datapath #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .angle_step_i (angle_step_q),
    .cmd_i        (cmd),
    .out_data_o   (out_data_o)
  );

endmodule
